@@ sv/bcsf_pkg.sv @@
// ----------------------------------------------------------------------------
// bcsf_pkg - shared types and constants of the base count sample filter
// Reason codes, configuration register indexes, lane numbering and the
// per-lane flag word handed from the lanes to the merge stage.
// ----------------------------------------------------------------------------
package bcsf_pkg;

    localparam int NUM_LANES    = 6;
    localparam int ACGT_LANES   = 4;
    localparam int OUT_W        = 32;
    localparam int THRESH_W     = 32;
    localparam int COV_W        = 34;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 34;
    localparam int TALLY_W      = 3;

    // lane numbering, A C G T first so ACGT lanes are 0..3
    localparam int LANE_A   = 0;
    localparam int LANE_C   = 1;
    localparam int LANE_G   = 2;
    localparam int LANE_T   = 3;
    localparam int LANE_N   = 4;
    localparam int LANE_DEL = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_COUNT    = 4'd0,
        REG_MAX_COUNT    = 4'd1,
        REG_MIN_COVERAGE = 4'd2,
        REG_MAX_COVERAGE = 4'd3,
        REG_TOLERATE_DEL = 4'd4,
        REG_CLEAR_FILT   = 4'd5,
        REG_SNP_MODE     = 4'd6,
        REG_ZERO_N_AND_D = 4'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        RSN_PASS          = 3'd0,
        RSN_DELETION      = 3'd1,
        RSN_EMPTY         = 3'd2,
        RSN_LOW_COVERAGE  = 3'd3,
        RSN_HIGH_COVERAGE = 3'd4,
        RSN_NOT_SNP       = 3'd5,
        RSN_NOT_BIALLELIC = 3'd6
    } reason_t;

    typedef struct packed {
        logic below;    // zeroed for being under the count floor
        logic above;    // zeroed for exceeding the count ceiling
        logic nonzero;  // value after zeroing is nonzero
        logic lt_min;   // original count under the count floor
    } lane_flags_t;

endpackage

@@ sv/bcsf_lane.sv @@
// ----------------------------------------------------------------------------
// bcsf_lane - one count lane of the sample filter
// Applies min/max zeroing to a single count and registers the zeroed value
// together with its flag word.
// ----------------------------------------------------------------------------
module bcsf_lane #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  load,
    input  logic                                  zero_en,
    input  logic [bcsf_pkg::THRESH_W-1:0]         cnt_floor,
    input  logic [bcsf_pkg::THRESH_W-1:0]         cnt_ceil,
    input  logic [COUNT_WIDTH-1:0]                count,
    output logic [COUNT_WIDTH-1:0]                value,
    output bcsf_pkg::lane_flags_t                 flags
);

    localparam int CW = (COUNT_WIDTH > bcsf_pkg::THRESH_W) ? COUNT_WIDTH
                                                           : bcsf_pkg::THRESH_W;

    logic [CW-1:0]           cnt_x;
    logic [CW-1:0]           min_x;
    logic [CW-1:0]           max_x;
    logic [CW-1:0]           after_min;
    logic                    lt;
    logic                    zero_below;
    logic                    zero_above;
    logic [COUNT_WIDTH-1:0]  value_next;
    logic [COUNT_WIDTH-1:0]  value_reg;
    bcsf_pkg::lane_flags_t   flags_next;
    bcsf_pkg::lane_flags_t   flags_reg;

    always_comb
    begin
        cnt_x      = CW'(count);
        min_x      = CW'(cnt_floor);
        max_x      = CW'(cnt_ceil);
        lt         = cnt_x < min_x;
        zero_below = (|cnt_floor) && lt && zero_en;
        after_min  = zero_below ? '0 : cnt_x;
        // a count already zeroed can never exceed max
        zero_above = (|cnt_ceil) && (after_min > max_x) && zero_en;
        value_next = zero_above ? '0 : after_min[COUNT_WIDTH-1:0];

        flags_next.below   = zero_below;
        flags_next.above   = zero_above;
        flags_next.nonzero = |value_next;
        flags_next.lt_min  = lt;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value_next;
            flags_reg <= flags_next;
        end
    end

    assign value = value_reg;
    assign flags = flags_reg;

endmodule

@@ sv/bcsf_merge.sv @@
// ----------------------------------------------------------------------------
// bcsf_merge - merge stage of the sample filter
// Combines the lane results: ACGT sum, allele count, tallies, the ordered
// pass/fail checks and the optional clearing; registers the result word.
// ----------------------------------------------------------------------------
module bcsf_merge #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              load,
    input  logic [bcsf_pkg::THRESH_W-1:0]     cnt_floor,
    input  logic [bcsf_pkg::COV_W-1:0]        cov_floor,
    input  logic [bcsf_pkg::COV_W-1:0]        cov_ceil,
    input  logic                              tolerate_del,
    input  logic                              clear_failed,
    input  logic [1:0]                        snp_mode,
    input  logic [COUNT_WIDTH-1:0]            vals  [bcsf_pkg::NUM_LANES],
    input  bcsf_pkg::lane_flags_t             flags [bcsf_pkg::NUM_LANES],
    output logic [bcsf_pkg::OUT_W-1:0]        outs  [bcsf_pkg::NUM_LANES],
    output logic                              passed,
    output logic [2:0]                        reason,
    output logic [bcsf_pkg::TALLY_W-1:0]      zeroed_below,
    output logic [bcsf_pkg::TALLY_W-1:0]      zeroed_above
);

    localparam int SUM_W = COUNT_WIDTH + 2;
    localparam int VW    = (SUM_W > bcsf_pkg::COV_W) ? SUM_W : bcsf_pkg::COV_W;

    logic [SUM_W-1:0]                sum;
    logic [VW-1:0]                   sum_x;
    logic [bcsf_pkg::TALLY_W-1:0]    alleles;
    logic [bcsf_pkg::TALLY_W-1:0]    below_next;
    logic [bcsf_pkg::TALLY_W-1:0]    above_next;
    logic                            del_fail;
    logic                            clr;
    bcsf_pkg::reason_t               reason_next;
    bcsf_pkg::reason_t               reason_reg;
    logic [bcsf_pkg::OUT_W-1:0]      outs_next [bcsf_pkg::NUM_LANES];
    logic [bcsf_pkg::OUT_W-1:0]      outs_reg  [bcsf_pkg::NUM_LANES];
    logic [bcsf_pkg::TALLY_W-1:0]    below_reg;
    logic [bcsf_pkg::TALLY_W-1:0]    above_reg;

    always_comb
    begin
        sum        = '0;
        alleles    = '0;
        below_next = '0;
        above_next = '0;
        for (int i = 0; i < bcsf_pkg::ACGT_LANES; i++)
        begin
            sum        = sum + SUM_W'(vals[i]);
            alleles    = alleles + bcsf_pkg::TALLY_W'(flags[i].nonzero);
            below_next = below_next + bcsf_pkg::TALLY_W'(flags[i].below);
            above_next = above_next + bcsf_pkg::TALLY_W'(flags[i].above);
        end
        // full-width sum; saturation at 64 bits would not change any compare
        sum_x = VW'(sum);

        // surviving deletion count is nonzero only if untouched, so >= min
        // reduces to "not below min" on the original count
        del_fail = !tolerate_del && (|cnt_floor)
                   && flags[bcsf_pkg::LANE_DEL].nonzero
                   && !flags[bcsf_pkg::LANE_DEL].lt_min;

        if (del_fail)
            reason_next = bcsf_pkg::RSN_DELETION;
        else if (sum == '0)
            reason_next = bcsf_pkg::RSN_EMPTY;
        else if (sum_x < VW'(cov_floor))
            reason_next = bcsf_pkg::RSN_LOW_COVERAGE;
        else if ((|cov_ceil) && (sum_x > VW'(cov_ceil)))
            reason_next = bcsf_pkg::RSN_HIGH_COVERAGE;
        else if (snp_mode[0] && (alleles < bcsf_pkg::TALLY_W'(2)))
            reason_next = bcsf_pkg::RSN_NOT_SNP;
        else if (snp_mode[1] && (alleles != bcsf_pkg::TALLY_W'(2)))
            reason_next = bcsf_pkg::RSN_NOT_BIALLELIC;
        else
            reason_next = bcsf_pkg::RSN_PASS;

        clr = (reason_next != bcsf_pkg::RSN_PASS) && clear_failed;
        for (int i = 0; i < bcsf_pkg::NUM_LANES; i++)
            outs_next[i] = clr ? '0 : bcsf_pkg::OUT_W'(vals[i]);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            reason_reg <= reason_next;
            outs_reg   <= outs_next;
            below_reg  <= below_next;
            above_reg  <= above_next;
        end
    end

    assign outs         = outs_reg;
    assign reason       = reason_reg;
    assign passed       = (reason_reg == bcsf_pkg::RSN_PASS);
    assign zeroed_below = below_reg;
    assign zeroed_above = above_reg;

endmodule

@@ sv/base_count_sample_filter_unit.sv @@
// ----------------------------------------------------------------------------
// base_count_sample_filter_unit - per-sample nucleotide count filter
// Top level: configuration registers, six count lanes, merge stage and the
// word handshake between them.
// ----------------------------------------------------------------------------
// Accepts one sample word per clock unless the result side stalls, and
// returns one result word per sample. The result word is registered in
// stages: the first register stage is the six parallel count lanes (min/max
// zeroing), the second is the merge stage (ACGT sum, coverage and allele
// checks, clearing). Both stages hold their word when the result side stalls,
// and a stage frees as soon as its word moves on, so full throughput is kept
// under back pressure. Configuration writes are never held off (cfg_ready is
// always high) and must only be issued while no sample is in flight.
module base_count_sample_filter_unit #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bcsf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bcsf_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  logic [COUNT_WIDTH-1:0]               count_a,
    input  logic [COUNT_WIDTH-1:0]               count_c,
    input  logic [COUNT_WIDTH-1:0]               count_g,
    input  logic [COUNT_WIDTH-1:0]               count_t,
    input  logic [COUNT_WIDTH-1:0]               count_n,
    input  logic [COUNT_WIDTH-1:0]               count_del,

    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic [bcsf_pkg::OUT_W-1:0]           out_a,
    output logic [bcsf_pkg::OUT_W-1:0]           out_c,
    output logic [bcsf_pkg::OUT_W-1:0]           out_g,
    output logic [bcsf_pkg::OUT_W-1:0]           out_t,
    output logic [bcsf_pkg::OUT_W-1:0]           out_n,
    output logic [bcsf_pkg::OUT_W-1:0]           out_del,
    output logic                                 passed,
    output logic [2:0]                           reason,
    output logic [bcsf_pkg::TALLY_W-1:0]         zeroed_below,
    output logic [bcsf_pkg::TALLY_W-1:0]         zeroed_above
);

    logic [bcsf_pkg::THRESH_W-1:0]  min_count_reg;
    logic [bcsf_pkg::THRESH_W-1:0]  max_count_reg;
    logic [bcsf_pkg::COV_W-1:0]     min_cov_reg;
    logic [bcsf_pkg::COV_W-1:0]     max_cov_reg;
    logic                           tol_del_reg;
    logic                           clear_filt_reg;
    logic [1:0]                     snp_mode_reg;
    logic                           zero_nd_reg;
    logic                           cfg_we;

    logic                           lane_valid_reg;
    logic                           lane_valid_next;
    logic                           res_valid_reg;
    logic                           res_valid_next;
    logic                           load_lane;
    logic                           load_res;

    logic [COUNT_WIDTH-1:0]         cnt   [bcsf_pkg::NUM_LANES];
    logic [COUNT_WIDTH-1:0]         vals  [bcsf_pkg::NUM_LANES];
    bcsf_pkg::lane_flags_t          flags [bcsf_pkg::NUM_LANES];
    logic [bcsf_pkg::OUT_W-1:0]     outs  [bcsf_pkg::NUM_LANES];

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_count_reg  <= '0;
            max_count_reg  <= '0;
            min_cov_reg    <= '0;
            max_cov_reg    <= '0;
            tol_del_reg    <= 1'b0;
            clear_filt_reg <= 1'b0;
            snp_mode_reg   <= '0;
            zero_nd_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bcsf_pkg::REG_MIN_COUNT:
                    min_count_reg <= cfg_data[bcsf_pkg::THRESH_W-1:0];
                bcsf_pkg::REG_MAX_COUNT:
                    max_count_reg <= cfg_data[bcsf_pkg::THRESH_W-1:0];
                bcsf_pkg::REG_MIN_COVERAGE:
                    min_cov_reg   <= cfg_data[bcsf_pkg::COV_W-1:0];
                bcsf_pkg::REG_MAX_COVERAGE:
                    max_cov_reg   <= cfg_data[bcsf_pkg::COV_W-1:0];
                bcsf_pkg::REG_TOLERATE_DEL:
                    tol_del_reg   <= cfg_data[0];
                bcsf_pkg::REG_CLEAR_FILT:
                    clear_filt_reg <= cfg_data[0];
                bcsf_pkg::REG_SNP_MODE:
                    snp_mode_reg  <= cfg_data[1:0];
                bcsf_pkg::REG_ZERO_N_AND_D:
                    zero_nd_reg   <= cfg_data[0];
                default:
                    ;   // unknown index: write dropped
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    assign load_res     = lane_valid_reg && (!res_valid_reg || result_ready);
    assign sample_ready = !lane_valid_reg || load_res;
    assign load_lane    = sample_valid && sample_ready;

    always_comb
    begin
        lane_valid_next = lane_valid_reg;
        if (load_lane)
            lane_valid_next = 1'b1;
        else if (load_res)
            lane_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (load_res)
            res_valid_next = 1'b1;
        else if (result_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            lane_valid_reg <= lane_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    assign result_valid = res_valid_reg;

    // ---------------- lanes ----------------
    assign cnt[bcsf_pkg::LANE_A]   = count_a;
    assign cnt[bcsf_pkg::LANE_C]   = count_c;
    assign cnt[bcsf_pkg::LANE_G]   = count_g;
    assign cnt[bcsf_pkg::LANE_T]   = count_t;
    assign cnt[bcsf_pkg::LANE_N]   = count_n;
    assign cnt[bcsf_pkg::LANE_DEL] = count_del;

    for (genvar g = 0; g < bcsf_pkg::NUM_LANES; g++)
    begin : g_lane
        // N and deletion lanes only zero when enabled
        bcsf_lane #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .clk       (clk),
            .load      (load_lane),
            .zero_en   ((g < bcsf_pkg::ACGT_LANES) ? 1'b1 : zero_nd_reg),
            .cnt_floor (min_count_reg),
            .cnt_ceil  (max_count_reg),
            .count     (cnt[g]),
            .value     (vals[g]),
            .flags     (flags[g])
        );
    end

    // ---------------- merge ----------------
    bcsf_merge #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_merge (
        .clk                (clk),
        .load               (load_res),
        .cnt_floor          (min_count_reg),
        .cov_floor          (min_cov_reg),
        .cov_ceil           (max_cov_reg),
        .tolerate_del       (tol_del_reg),
        .clear_failed       (clear_filt_reg),
        .snp_mode           (snp_mode_reg),
        .vals               (vals),
        .flags              (flags),
        .outs               (outs),
        .passed             (passed),
        .reason             (reason),
        .zeroed_below       (zeroed_below),
        .zeroed_above       (zeroed_above)
    );

    assign out_a   = outs[bcsf_pkg::LANE_A];
    assign out_c   = outs[bcsf_pkg::LANE_C];
    assign out_g   = outs[bcsf_pkg::LANE_G];
    assign out_t   = outs[bcsf_pkg::LANE_T];
    assign out_n   = outs[bcsf_pkg::LANE_N];
    assign out_del = outs[bcsf_pkg::LANE_DEL];

endmodule

@@ sv/bcsf_checker.sv @@
// ----------------------------------------------------------------------------
// bcsf_checker - port-level checks for the sample filter
// Watches the result port of the top level; attached by bind.
// ----------------------------------------------------------------------------
module bcsf_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            result_valid,
    input  logic                            result_ready,
    input  logic                            passed,
    input  logic [2:0]                      reason,
    input  logic [bcsf_pkg::TALLY_W-1:0]    zeroed_below,
    input  logic [bcsf_pkg::TALLY_W-1:0]    zeroed_above,
    input  logic [bcsf_pkg::OUT_W-1:0]      out_a
);

    // stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(reason)
            && $stable(out_a) && $stable(zeroed_below))
        else $error("result word changed while stalled");

    a_pass_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (passed == (reason == bcsf_pkg::RSN_PASS)))
        else $error("passed disagrees with reason");

    a_reason_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (reason <= bcsf_pkg::RSN_NOT_BIALLELIC))
        else $error("reason code out of range");

    // a count is zeroed at most once, so tallies share the four ACGT counts
    a_tally_total: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((4'(zeroed_below) + 4'(zeroed_above)) <= 4'd4))
        else $error("zeroing tallies exceed ACGT count");

endmodule

bind base_count_sample_filter_unit bcsf_checker u_bcsf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .passed       (passed),
    .reason       (reason),
    .zeroed_below (zeroed_below),
    .zeroed_above (zeroed_above),
    .out_a        (out_a)
);
